// ----- design/wocs_pkg.sv -----
// Package for the wiggle-order counting sort: constants, codes and payload structs.
package wocs_pkg;

  localparam int unsigned NumBins   = 8192;
  localparam int unsigned BinW      = $clog2(NumBins);
  localparam int unsigned CountW    = 16;
  localparam int unsigned PosW      = 16;
  localparam int unsigned ValW      = 13;

  localparam logic [CountW-1:0] MaxItems = 16'd65535;
  localparam logic [BinW-1:0]   TopBin   = BinW'(NumBins - 1);

  localparam logic KindLoad  = 1'b0;
  localparam logic KindFetch = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic [ValW-1:0] value_res;
    logic            last;
  } res_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_WR,
    ST_SCAN
  } state_e;

endpackage

// ----- design/wocs_hist_ram.sv -----
// Histogram memory: one write port, one read port with registered read data.
module wocs_hist_ram
  import wocs_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [BinW-1:0]   waddr_i,
  input  logic [CountW-1:0] wdata_i,
  input  logic [BinW-1:0]   raddr_i,
  output logic [CountW-1:0] rdata_o
);

  logic [CountW-1:0] mem [NumBins];
  logic [CountW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/wiggle_order_counting_sort.sv -----
// Top level of the wiggle-order counting sort: control sequencer around the histogram RAM.
//
//  channel   | signals                      | transaction
//  ----------+------------------------------+-------------------------------------
//  request   | start, busy, req_i           | taken at a clock edge with start & !busy
//  result    | res_valid_o, res_o           | one-cycle strobe, always taken
//
// Sequencing: a load reads the histogram entry, then writes back count + 1.
// A fetch reads the current bin, then steps down past each empty bin; the scan
// through the histogram RAM (one read per cycle) goes on to a nonempty bin or
// to bin 0. The result strobe comes in the cycle after the final scan step.
// Reset: after rst_ni releases, a clearing pass writes zero to all NumBins
// (8192) histogram entries, one per cycle; busy stays high meanwhile.
// The result side cannot stall; busy is the only flow control.
module wiggle_order_counting_sort
  import wocs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  // Control state
  state_e            state_q, state_d;
  logic [BinW-1:0]   clr_addr_q, clr_addr_d;
  logic [BinW-1:0]   ld_bin_q, ld_bin_d;
  logic [CountW-1:0] total_q, total_d;
  logic [BinW-1:0]   largest_q, largest_d;
  logic [BinW-1:0]   scan_q, scan_d;
  logic [PosW-1:0]   next_pos_q, next_pos_d;
  logic              draining_q, draining_d;
  logic [CountW-1:0] emitted_q, emitted_d;

  // Result register
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  // RAM port signals
  logic              ram_we;
  logic [BinW-1:0]   ram_waddr;
  logic [CountW-1:0] ram_wdata;
  logic [BinW-1:0]   ram_raddr;
  logic [CountW-1:0] ram_rdata;

  logic              accept;
  logic [BinW-1:0]   in_bin;
  logic [PosW:0]     pos_step;
  logic [CountW-1:0] emitted_inc;
  logic              bin_zero;

  wocs_hist_ram u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Values above the bin range land in the top bin.
  always_comb begin
    if (BinW'(req_i.value) > TopBin) begin
      in_bin = TopBin;
    end else begin
      in_bin = BinW'(req_i.value);
    end
  end

  assign bin_zero    = (ram_rdata == '0);
  assign pos_step    = {1'b0, next_pos_q} + (PosW+1)'(2);
  assign emitted_inc = emitted_q + CountW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      total_q     <= '0;
      largest_q   <= '0;
      scan_q      <= '0;
      next_pos_q  <= PosW'(1);
      draining_q  <= 1'b0;
      emitted_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      total_q     <= total_d;
      largest_q   <= largest_d;
      scan_q      <= scan_d;
      next_pos_q  <= next_pos_d;
      draining_q  <= draining_d;
      emitted_q   <= emitted_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    ld_bin_q <= ld_bin_d;
    res_q    <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    ld_bin_d    = ld_bin_q;
    total_d     = total_q;
    largest_d   = largest_q;
    scan_d      = scan_q;
    next_pos_d  = next_pos_q;
    draining_d  = draining_q;
    emitted_d   = emitted_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = scan_q;
    ram_wdata   = '0;
    ram_raddr   = scan_q;

    unique case (state_q)
      ST_CLEAR: begin
        // Post-reset sweep: zero one histogram entry per cycle.
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + BinW'(1);
        if (clr_addr_q == TopBin) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          if (req_i.kind == KindLoad) begin
            // Loads are dropped while draining or once the count is full.
            if (!draining_q && (total_q < MaxItems)) begin
              ram_raddr = in_bin;
              ld_bin_d  = in_bin;
              total_d   = total_q + CountW'(1);
              if (in_bin > largest_q) begin
                largest_d = in_bin;
              end
              state_d = ST_LOAD_WR;
            end
          end else begin
            if (draining_q) begin
              state_d = ST_SCAN;
            end else if (total_q != '0) begin
              // First fetch opens the drain from the largest bin.
              draining_d = 1'b1;
              scan_d     = largest_q;
              ram_raddr  = largest_q;
              emitted_d  = '0;
              next_pos_d = (total_q > CountW'(1)) ? PosW'(1) : '0;
              state_d    = ST_SCAN;
            end
          end
        end
      end

      ST_LOAD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ld_bin_q;
        ram_wdata = ram_rdata + CountW'(1);
        state_d   = ST_IDLE;
      end

      ST_SCAN: begin
        if (bin_zero && (scan_q != '0)) begin
          // Empty bin: step down and read the next one.
          scan_d    = scan_q - BinW'(1);
          ram_raddr = scan_q - BinW'(1);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = scan_q;
          ram_wdata = bin_zero ? '0 : (ram_rdata - CountW'(1));

          res_valid_d       = 1'b1;
          res_d.position    = next_pos_q;
          res_d.value_res   = ValW'(scan_q);
          res_d.last        = (emitted_inc >= total_q);
          emitted_d         = emitted_inc;

          // Odd positions first; past the end of the odd run, wrap to zero.
          if ((pos_step >= {1'b0, total_q}) && pos_step[0]) begin
            next_pos_d = '0;
          end else begin
            next_pos_d = pos_step[PosW-1:0];
          end

          if (emitted_inc >= total_q) begin
            draining_d = 1'b0;
            total_d    = '0;
            largest_d  = '0;
            scan_d     = '0;
            next_pos_d = PosW'(1);
            emitted_d  = '0;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
